// ----- sv/swg_pkg.sv -----
// swg_pkg: shared types and constants of the sine waveform generator
// used by swg_ctrl, swg_dp and sine_waveform_generator; no dependencies
package swg_pkg;

   localparam int TABLE_LEN = 24;
   localparam int STAGE_W   = 5;
   localparam int CORDIC_W  = 34;
   localparam int SINE_W    = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_OFFSET = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_OFFSET = 2'd3;

   // cordic gain, 2^30 scale
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

   // arctan(2^-i) in turn/2^32 units
   localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ROUND,
      ST_MULT,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic               load;     // capture angle, advance phase
      logic               rotate;   // one cordic iteration
      logic [STAGE_W-1:0] stage;
      logic               round;    // round and clamp sine
      logic               mult;     // amplitude times sine
      logic               out_load; // final sum into output register
   } cmd_type;

endpackage

// ----- sv/swg_ctrl.sv -----
// swg_ctrl: controller state machine of the sine waveform generator
// depends on swg_pkg; drives swg_dp through cmd_type
module swg_ctrl #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             tick,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output swg_pkg::cmd_type cmd
);
   import swg_pkg::*;

   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);

   state_type          state_ff, state_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic               valid_ff, valid_in;
   logic               accept;
   logic               slot_free;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && tick) state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (stage_ff == LAST_STAGE) state_in = ST_ROUND;
         end
         ST_ROUND: state_in = ST_MULT;
         ST_MULT:  state_in = ST_SUM;
         ST_SUM: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.stage    = stage_ff;
      stage_in     = stage_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = accept && tick;
            stage_in   = '0;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            stage_in   = stage_ff + 1'b1;
         end
         ST_ROUND: cmd.round = 1'b1;
         ST_MULT:  cmd.mult = 1'b1;
         ST_SUM:   cmd.out_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      priority if (cmd.out_load) valid_in = 1'b1;
      else if (rsp_tready)       valid_in = 1'b0;
      else                       valid_in = valid_ff;
   end

   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         valid_ff <= valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!valid_ff || rsp_tready))
      else $error("result register overwritten while a beat waits");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && tick) |=> (state_ff == ST_ROTATE && stage_ff == '0))
      else $error("sample request did not start the rotation");

   a_idle_item: assert property (@(posedge clock) disable iff (reset)
      (accept && !tick) |=> (state_ff == ST_IDLE && !cmd.out_load))
      else $error("item without tick started work");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (stage_ff <= LAST_STAGE))
      else $error("cordic stage counter out of range");

endmodule

// ----- sv/swg_dp.sv -----
// swg_dp: datapath of the sine waveform generator: registers, phase accumulator,
// iterative cordic, multiply, offset and saturation; depends on swg_pkg
module swg_dp #(
   parameter int PHASE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swg_pkg::cmd_type               cmd,
   input  logic                           csr_wen,
   input  logic [swg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swg_pkg::DATA_W-1:0]     csr_wdata,
   output logic [swg_pkg::DATA_W-1:0]     sample
);
   import swg_pkg::*;

   logic signed [DATA_W-1:0]   amplitude_ff;
   logic        [31:0]         phase_step_ff;
   logic        [31:0]         phase_offset_ff;
   logic signed [DATA_W-1:0]   level_offset_ff;
   logic        [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;

   logic        [31:0]         acc_top;
   logic        [PHASE_BITS-1:0] step_al;
   logic        [31:0]         angle, folded;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORDIC_W-1:0] dx, dy, atan_z, y_rnd;
   logic signed [SINE_W-1:0]   sine_ff, sine_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   sum;
   logic        [DATA_W-1:0]   sample_ff, sample_in;

   function automatic logic signed [PROD_W-1:0] sine_in_reg_ext(logic signed [SINE_W-1:0] s);
      return {{(PROD_W-SINE_W){s[SINE_W-1]}}, s};
   endfunction

   // align accumulator and step to a 32-bit turn fraction
   if (PHASE_BITS >= 32) begin : g_wide
      assign acc_top = phase_acc_ff[PHASE_BITS-1 -: 32];
      assign step_al = PHASE_BITS'(phase_step_ff) << (PHASE_BITS - 32);
   end else begin : g_narrow
      assign acc_top = 32'(phase_acc_ff) << (32 - PHASE_BITS);
      assign step_al = PHASE_BITS'(phase_step_ff >> (32 - PHASE_BITS));
   end

   // fold second and third quadrant with sin(t) = sin(half turn - t)
   always_comb begin
      angle  = acc_top + phase_offset_ff;
      folded = angle;
      if (angle[31:30] == 2'b01 || angle[31:30] == 2'b10) folded = 32'h8000_0000 - angle;
   end

   assign phase_acc_in = phase_acc_ff + step_al;

   always_comb begin
      dx     = y_ff >>> cmd.stage;
      dy     = x_ff >>> cmd.stage;
      atan_z = CORDIC_W'(ATAN_TURNS[cmd.stage]);
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      priority if (cmd.load) begin
         x_in = GAIN_Q30;
         y_in = '0;
         z_in = {{(CORDIC_W-32){folded[31]}}, folded};
      end else if (cmd.rotate) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_z;
         end
      end else begin
         x_in = x_ff;
         y_in = y_ff;
         z_in = z_ff;
      end
   end

   // round y to q1.15 and clamp
   always_comb begin
      y_rnd = (y_ff + CORDIC_W'(16384)) >>> 15;
      if (y_rnd[CORDIC_W-1:SINE_W-1] == '0 || y_rnd[CORDIC_W-1:SINE_W-1] == '1)
         sine_in = y_rnd[SINE_W-1:0];
      else
         sine_in = y_rnd[CORDIC_W-1] ? {1'b1, {(SINE_W-1){1'b0}}} : {1'b0, {(SINE_W-1){1'b1}}};
   end

   assign prod_in = amplitude_ff * sine_in_reg_ext(sine_ff);

   // round product, add level, saturate to 32 bits
   always_comb begin
      sum = ((prod_ff + PROD_W'(16384)) >>> 15)
            + $signed({{(PROD_W-DATA_W){level_offset_ff[DATA_W-1]}}, level_offset_ff});
      if (sum[PROD_W-1:DATA_W-1] == '0 || sum[PROD_W-1:DATA_W-1] == '1)
         sample_in = sum[DATA_W-1:0];
      else
         sample_in = sum[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= '0;
         phase_step_ff   <= '0;
         phase_offset_ff <= '0;
         level_offset_ff <= '0;
         phase_acc_ff    <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               REG_AMPLITUDE:    amplitude_ff    <= csr_wdata;
               REG_PHASE_STEP:   phase_step_ff   <= csr_wdata;
               REG_PHASE_OFFSET: phase_offset_ff <= csr_wdata;
               REG_LEVEL_OFFSET: level_offset_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) phase_acc_ff <= phase_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.round)    sine_ff   <= sine_in;
      if (cmd.mult)     prod_ff   <= prod_in;
      if (cmd.out_load) sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

// ----- sv/sine_waveform_generator.sv -----
// sine_waveform_generator: top level, direct digital synthesis of a sine sample per tick
// depends on swg_pkg, swg_ctrl and swg_dp
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata[0] tick
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata[31:0] sample, q16.16
//   csr_     in   csr_wen                csr_index, csr_wdata
//
// a tick goes from acceptance to the result register as follows:
// the cordic does one iteration a cycle, then round, multiply and sum follow in turn;
// the next request is taken only once the sum step is done and the controller is idle
// a beat with tick low is taken in idle and gives no result
// reset is synchronous and clears the csr registers, the phase and the result valid
// a waiting result does not block the next request; a finished sample waits in its
// last step until the result register is free
module sine_waveform_generator #(
   parameter int PHASE_BITS    = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [0] tick, [7:1] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swg_pkg::DATA_W-1:0]    rsp_tdata,  // [31:0] sample
   input  logic                          csr_wen,
   input  logic [swg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swg_pkg::DATA_W-1:0]    csr_wdata
);
   import swg_pkg::*;

   cmd_type cmd;

   swg_ctrl #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .tick       (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   swg_dp #(
      .PHASE_BITS(PHASE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (rsp_tdata)
   );

endmodule
